// ----- rtl/core/assert_macros.svh -----
// Assertion helpers shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expr must hold at every clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rstn, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (expr)) else $error(msg);

// cons must hold in the same cycle as ante
`define ASSERT_IMPLIES(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

`endif

// ----- rtl/core/wrgsd_pkg.sv -----
`default_nettype none

package wrgsd_pkg;

    localparam int WORD_LIMIT  = 24;
    localparam int STORE_DEPTH = WORD_LIMIT - 1;
    localparam int CNT_W       = $clog2(WORD_LIMIT);
    localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int GROUP_SIZE  = 14;
    localparam int SUM_W       = $clog2(GROUP_SIZE + WORD_LIMIT);
    localparam int WRAP_STEPS  = (GROUP_SIZE + WORD_LIMIT) / GROUP_SIZE + 1;

    localparam int Q_DEPTH     = 4;
    localparam int Q_PTR_W     = $clog2(Q_DEPTH);
    localparam int Q_CNT_W     = $clog2(Q_DEPTH + 1);

    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;

    // abcdghijkoqtuv
    localparam logic [7:0] GROUP_TAB [GROUP_SIZE] = '{
        8'h61, 8'h62, 8'h63, 8'h64, 8'h67, 8'h68, 8'h69,
        8'h6A, 8'h6B, 8'h6F, 8'h71, 8'h74, 8'h75, 8'h76
    };

    typedef struct packed {
        logic [7:0] char_in;
        logic       line_end;
    } in_item_t;

    typedef struct packed {
        logic [7:0] char_out;
        logic       run_last;
        logic       line_done;
    } out_item_t;

    // Command handed from the classifier to the executer
    typedef struct packed {
        logic [7:0] char_val;
        logic       store;
        logic       flush;
        logic       emit;
        logic       line_end;
    } cmd_t;

    typedef struct packed {
        logic             idle;
        logic [CNT_W-1:0] cnt;
    } bk_status_t;

    function automatic logic is_letter(input logic [7:0] c);
        return ((c >= CHAR_UPPER_A) && (c <= CHAR_UPPER_Z)) ||
               ((c >= CHAR_LOWER_A) && (c <= CHAR_LOWER_Z));
    endfunction

    // Rotate a group letter k places forward; other bytes pass unchanged
    function automatic logic [7:0] group_shift(input logic [7:0] c,
                                               input logic [CNT_W-1:0] k);
        logic             found;
        logic [SUM_W-1:0] idx;
        logic [SUM_W-1:0] sum;
        found = 1'b0;
        idx   = '0;
        for (int i = 0; i < GROUP_SIZE; i++) begin
            if (GROUP_TAB[i] == c) begin
                found = 1'b1;
                idx   = SUM_W'(i);
            end
        end
        sum = idx + SUM_W'(k);
        for (int j = 0; j < WRAP_STEPS; j++) begin
            if (sum >= SUM_W'(GROUP_SIZE)) begin
                sum = sum - SUM_W'(GROUP_SIZE);
            end
        end
        return found ? GROUP_TAB[sum[$clog2(GROUP_SIZE)-1:0]] : c;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/wrgsd_front.sv -----
`default_nettype none

module wrgsd_front (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      s_valid,
    output logic                           s_ready,
    input  wire wrgsd_pkg::in_item_t       s_data,
    output logic                           q_push,
    output wrgsd_pkg::cmd_t                q_cmd,
    input  wire logic                      q_full,
    output logic [wrgsd_pkg::CNT_W-1:0]    fr_cnt
);
    import wrgsd_pkg::*;

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             ovf_reg, ovf_next;
    logic             letter;

    assign s_ready = !q_full;
    assign q_push  = s_valid && s_ready;
    assign letter  = is_letter(s_data.char_in);
    assign fr_cnt  = cnt_reg;

    always_comb begin
        cnt_next         = cnt_reg;
        ovf_next         = ovf_reg;
        q_cmd.char_val   = s_data.char_in;
        q_cmd.store      = 1'b0;
        q_cmd.flush      = 1'b1;
        q_cmd.emit       = 1'b1;
        q_cmd.line_end   = s_data.line_end;
        if (letter) begin
            if (ovf_reg) begin
                // pass through the tail of a long word
                q_cmd.flush = s_data.line_end;
            end else if (cnt_reg < CNT_W'(STORE_DEPTH)) begin
                q_cmd.char_val = group_shift(s_data.char_in, cnt_reg + CNT_W'(1));
                q_cmd.store    = 1'b1;
                q_cmd.flush    = s_data.line_end;
                q_cmd.emit     = 1'b0;
                cnt_next       = cnt_reg + CNT_W'(1);
            end else begin
                cnt_next = '0;
                ovf_next = 1'b1;
            end
        end else begin
            cnt_next = '0;
            ovf_next = 1'b0;
        end
        if (s_data.line_end) begin
            cnt_next = '0;
            ovf_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            ovf_reg <= 1'b0;
        end else if (q_push) begin
            cnt_reg <= cnt_next;
            ovf_reg <= ovf_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/wrgsd_fifo.sv -----
`default_nettype none

module wrgsd_fifo (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              push,
    input  wire wrgsd_pkg::cmd_t   push_data,
    output logic                   full,
    input  wire logic              pop,
    output wrgsd_pkg::cmd_t        pop_data,
    output logic                   empty
);
    import wrgsd_pkg::*;

    cmd_t               entry_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [Q_CNT_W-1:0] count_reg;

    assign full     = (count_reg == Q_CNT_W'(Q_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = entry_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + Q_PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + Q_PTR_W'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + Q_CNT_W'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - Q_CNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/wrgsd_back.sv -----
`default_nettype none

module wrgsd_back (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire wrgsd_pkg::cmd_t      q_cmd,
    input  wire logic                 q_empty,
    output logic                      q_pop,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output wrgsd_pkg::out_item_t      m_data,
    output wrgsd_pkg::bk_status_t     bk_stat
);
    import wrgsd_pkg::*;

    localparam logic [1:0] BK_IDLE   = 2'd0;
    localparam logic [1:0] BK_EXEC   = 2'd1;
    localparam logic [1:0] BK_RDWAIT = 2'd2;

    logic [1:0]       state_reg, state_next;
    cmd_t             cmd_reg, cmd_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             last_reg, last_next;
    logic [7:0]       rd_data_reg;
    logic [7:0]       mem [STORE_DEPTH];
    logic             mem_we, rd_en;
    logic [CNT_W-1:0] cnt_dec;
    logic             out_free, out_load;
    out_item_t        out_next;
    logic             m_valid_reg;
    out_item_t        m_data_reg;

    assign cnt_dec  = cnt_reg - CNT_W'(1);
    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;
    assign bk_stat.idle = (state_reg == BK_IDLE);
    assign bk_stat.cnt  = cnt_reg;

    always_comb begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        cnt_next   = cnt_reg;
        last_next  = last_reg;
        q_pop      = 1'b0;
        mem_we     = 1'b0;
        rd_en      = 1'b0;
        out_load   = 1'b0;
        out_next   = '0;
        unique case (state_reg)
            BK_IDLE: begin
                if (!q_empty) begin
                    q_pop      = 1'b1;
                    cmd_next   = q_cmd;
                    state_next = BK_EXEC;
                end
            end
            BK_EXEC: begin
                if (cmd_reg.store) begin
                    mem_we         = 1'b1;
                    cnt_next       = cnt_reg + CNT_W'(1);
                    cmd_next.store = 1'b0;
                    if (!cmd_reg.flush && !cmd_reg.emit) begin
                        state_next = BK_IDLE;
                    end
                end else if (cmd_reg.flush && (cnt_reg != '0)) begin
                    // read the newest letter, newest first
                    rd_en      = 1'b1;
                    cnt_next   = cnt_dec;
                    last_next  = (cnt_dec == '0) && !cmd_reg.emit;
                    state_next = BK_RDWAIT;
                end else if (cmd_reg.emit) begin
                    if (out_free) begin
                        out_load           = 1'b1;
                        out_next.char_out  = cmd_reg.char_val;
                        out_next.run_last  = 1'b1;
                        out_next.line_done = cmd_reg.line_end;
                        state_next         = BK_IDLE;
                    end
                end else begin
                    state_next = BK_IDLE;
                end
            end
            BK_RDWAIT: begin
                if (out_free) begin
                    out_load           = 1'b1;
                    out_next.char_out  = rd_data_reg;
                    out_next.run_last  = last_reg;
                    out_next.line_done = last_reg && cmd_reg.line_end;
                    state_next         = BK_EXEC;
                end
            end
            default: begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[cnt_reg[ADDR_W-1:0]] <= cmd_reg.char_val;
        end
        if (rd_en) begin
            rd_data_reg <= mem[cnt_dec[ADDR_W-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg  <= cmd_next;
        last_reg <= last_next;
        if (out_load) begin
            m_data_reg <= out_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= BK_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/word_reverse_group_shift_decoder.sv -----
// A pass-through byte goes through the command queue, the back end's command
// register and the output register; a flushed word adds a registered read of
// the word buffer per letter. The back end takes a new request from the queue
// only once it has finished the last one, and stalls while the output is held.
// Reset: synchronous, active low; clears counts, the command queue and the
// output valid flag; the word buffer contents stay undefined.
`default_nettype none

`include "assert_macros.svh"

module word_reverse_group_shift_decoder (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire wrgsd_pkg::in_item_t   s_data,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output wrgsd_pkg::out_item_t       m_data
);
    import wrgsd_pkg::*;

    logic             q_push, q_full, q_pop, q_empty;
    cmd_t             push_cmd, pop_cmd;
    logic [CNT_W-1:0] fr_cnt;
    bk_status_t       bk_stat;

    wrgsd_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_push  (q_push),
        .q_cmd   (push_cmd),
        .q_full  (q_full),
        .fr_cnt  (fr_cnt)
    );

    wrgsd_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (push_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (pop_cmd),
        .empty     (q_empty)
    );

    wrgsd_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_cmd   (pop_cmd),
        .q_empty (q_empty),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .bk_stat (bk_stat)
    );

    `ASSERT_IMPLIES(a_done_is_last, aclk, aresetn, m_valid && m_data.line_done, m_data.run_last, "line_done without run_last")
    `ASSERT_IMPLIES(a_cnt_in_sync, aclk, aresetn, q_empty && bk_stat.idle, fr_cnt == bk_stat.cnt, "front and back word counts differ")
    `ASSERT_ALWAYS(a_cnt_range, aclk, aresetn, bk_stat.cnt <= CNT_W'(STORE_DEPTH), "word count beyond buffer depth")

endmodule

`default_nettype wire
